// File: rtl/pcqd_pkg.sv
// Shared constants, entry type and helper functions of the priority class queue.
package pcqd_pkg;

    localparam int CAPACITY = 32;
    localparam int BUCKETS  = 10;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ID_W  = 16;
    localparam int CLS_W = 2;
    localparam int BKT_W = 4;
    localparam int STS_W = 2;

    localparam logic [PTR_W:0]   CAP_EXT = (PTR_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DRAIN  = 1'b1;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    localparam logic [CLS_W-1:0] CLS_BOTH       = 2'd0;
    localparam logic [CLS_W-1:0] CLS_IMPACT     = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LIKELIHOOD = 2'd2;
    localparam logic [CLS_W-1:0] CLS_NONE       = 2'd3;

    // class in the upper bits, so a plain compare orders by class, then id
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef logic [BKT_W-1:0] mod_tbl_t [256];

    function automatic mod_tbl_t build_mod_tbl();
        mod_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = BKT_W'(i % BUCKETS);
        end
        return t;
    endfunction

    localparam mod_tbl_t MOD_TBL = build_mod_tbl();

    function automatic logic [CLS_W-1:0] class_of(input logic impact, input logic likelihood);
        logic [CLS_W-1:0] c;
        if (impact && likelihood) begin
            c = CLS_BOTH;
        end else if (impact) begin
            c = CLS_IMPACT;
        end else if (likelihood) begin
            c = CLS_LIKELIHOOD;
        end else begin
            c = CLS_NONE;
        end
        return c;
    endfunction

    // fold one nibble at a time, remainder stays below BUCKETS
    function automatic logic [BKT_W-1:0] bucket_of(input logic [ID_W-1:0] id);
        logic [BKT_W-1:0] r;
        r = '0;
        for (int i = ID_W / 4 - 1; i >= 0; i--) begin
            r = MOD_TBL[{r, id[4*i +: 4]}];
        end
        return r;
    endfunction

endpackage

// File: rtl/priority_class_queue_drain.sv
// Priority class queue with class drain, held in a ring memory.
//
//  channel | direction | tdata (lsb up)                         | tuser | tlast
//  s_      | in        | id[15:0] impact[16] likelihood[17]     | mode  | -
//  m_      | out       | out_id[15:0] class[17:16] bucket[21:18] | -     | last
//          |           | status[23:22]                          |       |
//
// Insert: result on acceptance; the ordered placement then walks down from
// the tail, one memory read and one shift write a cycle, over the single memory port pair.
// Drain: the head is read first, then one popped word a cycle while m_tready holds;
// the last word leaves from ST_DR_LAST, entered also where the entry behind the drained class differs in class.
// Reset clears the count, head pointer, state and output valid; memory is not cleared.
// s_tready is low while an insert places or a drain runs, and while the output word waits.
module priority_class_queue_drain (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // id[15:0], impact[16], likelihood[17], zero[23:18]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_id[15:0], out_class[17:16], bucket[21:18], status[23:22]
    output logic        m_tlast
);
    import pcqd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_INS_SCAN = 6'b000010,
        ST_INS_PUT  = 6'b000100,
        ST_DR_FIRST = 6'b001000,
        ST_DR_NEXT  = 6'b010000,
        ST_DR_LAST  = 6'b100000
    } state_t;

    entry_t mem [CAPACITY];

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] k_reg, k_next;
    entry_t           new_reg, new_next;
    entry_t           pend_reg, pend_next;
    entry_t           rdata_reg;

    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  m_id_reg, m_id_next;
    logic [CLS_W-1:0] m_cls_reg, m_cls_next;
    logic [BKT_W-1:0] m_bkt_reg, m_bkt_next;
    logic [STS_W-1:0] m_sts_reg, m_sts_next;
    logic             m_last_reg, m_last_next;

    logic [PTR_W-1:0] rd_off, wr_off, rd_addr, wr_addr;
    logic             wr_en;
    entry_t           wr_data;
    logic             out_free, s_fire, full;
    entry_t           in_entry;

    logic             ld;
    logic [ID_W-1:0]  ld_id;
    logic [CLS_W-1:0] ld_cls;
    logic [STS_W-1:0] ld_sts;
    logic             ld_last;

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [PTR_W-1:0] off);
        logic [PTR_W:0] s;
        s = {1'b0, head} + {1'b0, off};
        if (s >= CAP_EXT) begin
            s = s - CAP_EXT;
        end
        return s[PTR_W-1:0];
    endfunction

    assign out_free     = !m_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) && out_free;
    assign s_fire       = s_tvalid && s_tready;
    assign full         = (count_reg == CAP_CNT);
    assign in_entry.id  = s_tdata[15:0];
    assign in_entry.cls = class_of(s_tdata[16], s_tdata[17]);
    assign rd_addr      = phys(head_reg, rd_off);
    assign wr_addr      = phys(head_reg, wr_off);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_sts_reg, m_bkt_reg, m_cls_reg, m_id_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        new_next   = new_reg;
        pend_next  = pend_reg;
        rd_off     = '0;
        wr_off     = '0;
        wr_en      = 1'b0;
        wr_data    = new_reg;
        ld         = 1'b0;
        ld_id      = pend_reg.id;
        ld_cls     = pend_reg.cls;
        ld_sts     = STS_OK;
        ld_last    = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ld = 1'b1;
                    if (s_tuser == MODE_INSERT) begin
                        ld_id  = in_entry.id;
                        ld_cls = in_entry.cls;
                        ld_sts = full ? STS_FULL : STS_OK;
                        if (!full) begin
                            if (count_reg == '0) begin
                                wr_en      = 1'b1;
                                wr_data    = in_entry;
                                count_next = count_reg + 1'b1;
                            end else begin
                                new_next   = in_entry;
                                k_next     = PTR_W'(count_reg - 1'b1);
                                rd_off     = PTR_W'(count_reg - 1'b1);
                                state_next = ST_INS_SCAN;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            ld_id  = '0;
                            ld_cls = '0;
                            ld_sts = STS_EMPTY;
                        end else begin
                            ld         = 1'b0;
                            state_next = ST_DR_FIRST;
                        end
                    end
                end
            end
            ST_INS_SCAN: begin
                wr_en  = 1'b1;
                wr_off = k_reg + 1'b1;
                if (rdata_reg > new_reg) begin
                    wr_data = rdata_reg;
                    if (k_reg == '0) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        k_next = k_reg - 1'b1;
                        rd_off = k_reg - 1'b1;
                    end
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INS_PUT: begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_DR_FIRST: begin
                pend_next  = rdata_reg;
                head_next  = phys(head_reg, PTR_W'(1));
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    state_next = ST_DR_LAST;
                end else begin
                    rd_off     = PTR_W'(1);
                    state_next = ST_DR_NEXT;
                end
            end
            ST_DR_NEXT: begin
                if (rdata_reg.cls != pend_reg.cls) begin
                    state_next = ST_DR_LAST;
                end else if (out_free) begin
                    ld         = 1'b1;
                    ld_last    = 1'b0;
                    pend_next  = rdata_reg;
                    head_next  = phys(head_reg, PTR_W'(1));
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_DR_LAST;
                    end else begin
                        rd_off = PTR_W'(1);
                    end
                end
            end
            ST_DR_LAST: begin
                if (out_free) begin
                    ld         = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_id_next    = m_id_reg;
        m_cls_next   = m_cls_reg;
        m_bkt_next   = m_bkt_reg;
        m_sts_next   = m_sts_reg;
        m_last_next  = m_last_reg;
        if (ld) begin
            m_valid_next = 1'b1;
            m_id_next    = ld_id;
            m_cls_next   = ld_cls;
            m_bkt_next   = bucket_of(ld_id);
            m_sts_next   = ld_sts;
            m_last_next  = ld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        new_reg    <= new_next;
        pend_reg   <= pend_next;
        m_id_reg   <= m_id_next;
        m_cls_reg  <= m_cls_next;
        m_bkt_reg  <= m_bkt_next;
        m_sts_reg  <= m_sts_next;
        m_last_reg <= m_last_next;
    end

endmodule
